FILE: design/csp_pkg.sv
package csp_pkg;

  // field widths
  localparam int COORD_W     = 16;
  localparam int TENS_W      = 10;
  localparam int GRAIN_W     = 5;
  localparam int MAX_SAMPLES = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  // datapath widths
  localparam int K_W   = 12;              // signed matrix weight
  localparam int CF_W  = COORD_W + 14;    // segment coefficient
  localparam int NW    = COORD_W + 30;    // sample numerator
  localparam int MW    = NW - 8;          // numerator after the 256 scale
  localparam int GSQ_W = 10;
  localparam int GCU_W = 15;
  localparam int DC_W  = $clog2(MW + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS  = 2'd1;

  localparam logic [TENS_W-1:0]  TENSION_RST = 10'd128;
  localparam logic [GRAIN_W-1:0] POINTS_RST  = 5'd8;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic                      first_point;
    logic                      last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      last_of_run;
    logic                      curve_end;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_COEF, ST_HORN, ST_DIV_INIT, ST_DIV_LOAD,
    ST_DIV_WAIT, ST_EMIT, ST_AFTER, ST_POINT
  } state_t;

  // one multiply-accumulate term of the cardinal matrix
  typedef enum logic [3:0] {
    TERM_A0, TERM_A1, TERM_A2, TERM_A3,
    TERM_B0, TERM_B1, TERM_B2, TERM_B3,
    TERM_C0, TERM_C2
  } term_t;

  typedef struct packed {
    logic               load_cur;
    logic               fill;
    logic               shift;
    logic               dup;
    logic               mac_en;
    term_t              term;
    logic               horn_en;
    logic [1:0]         horn_step;
    logic [GRAIN_W-1:0] j;
    logic               div_init;
    logic               div_load;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
  } lane_stat_t;

  typedef struct packed {
    logic emit;
    logic point;
    logic last_of_run;
    logic curve_end;
  } emit_t;

endpackage

FILE: design/csp_lane.sv
module csp_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  csp_pkg::lane_cmd_t                 cmd,
  input  logic signed [csp_pkg::COORD_W-1:0] coord,
  input  logic [csp_pkg::TENS_W-1:0]         tension,
  input  logic [csp_pkg::GRAIN_W-1:0]        grain,
  output csp_pkg::lane_stat_t                stat,
  output logic signed [csp_pkg::COORD_W-1:0] res,
  output logic signed [csp_pkg::COORD_W-1:0] pt
);

  localparam int CW = csp_pkg::COORD_W;
  localparam int CF = csp_pkg::CF_W;
  localparam int NW = csp_pkg::NW;
  localparam int MW = csp_pkg::MW;
  localparam int KW = csp_pkg::K_W;

  logic signed [CW-1:0] p0, p1, p2, cur;
  logic signed [CF-1:0] ca, cb, cc;
  logic [csp_pkg::GSQ_W-1:0] gsq;
  logic [csp_pkg::GCU_W-1:0] gcu;
  logic signed [NW-1:0] acc;
  logic signed [MW-1:0] msig;
  logic                 neg;
  logic [MW-1:0]        q;
  logic [csp_pkg::GCU_W-1:0] rem;
  logic [csp_pkg::DC_W-1:0]  cnt;
  logic                 busy;

  logic signed [CW-1:0] p3, psel;
  logic signed [KW-1:0] k, t12;
  logic signed [CF-1:0] prod;
  logic signed [NW-1:0] coef_sel, aj, cg, biased;
  logic [csp_pkg::GCU_W-1:0] gpow;
  logic [MW-1:0]        mag;
  logic [csp_pkg::GCU_W:0] trial;
  logic                 qbit;
  logic signed [CW-1:0] sat;

  assign p3   = cmd.dup ? p2 : cur;
  assign pt   = p2;
  assign stat.busy = busy;

  // matrix weight and knot for the current term
  always_comb begin
    t12  = $signed({{(KW-csp_pkg::TENS_W){1'b0}}, tension});
    k    = t12;
    psel = p0;
    case (cmd.term)
      csp_pkg::TERM_A0: begin k = -t12;                psel = p0; end
      csp_pkg::TERM_A1: begin k = 12'sd512 - t12;      psel = p1; end
      csp_pkg::TERM_A2: begin k = t12 - 12'sd512;      psel = p2; end
      csp_pkg::TERM_A3: begin k = t12;                 psel = p3; end
      csp_pkg::TERM_B0: begin k = t12 <<< 1;           psel = p0; end
      csp_pkg::TERM_B1: begin k = t12 - 12'sd768;      psel = p1; end
      csp_pkg::TERM_B2: begin k = 12'sd768 - (t12 <<< 1); psel = p2; end
      csp_pkg::TERM_B3: begin k = -t12;                psel = p3; end
      csp_pkg::TERM_C0: begin k = -t12;                psel = p0; end
      csp_pkg::TERM_C2: begin k = t12;                 psel = p2; end
      default:          begin k = t12;                 psel = p0; end
    endcase
    prod = $signed({{(CF-KW){k[KW-1]}}, k}) * $signed({{(CF-CW){psel[CW-1]}}, psel});
  end

  // horner step operands
  always_comb begin
    case (cmd.horn_step)
      2'd1: begin
        coef_sel = {{(NW-CF){cb[CF-1]}}, cb};
        gpow     = {{(csp_pkg::GCU_W-csp_pkg::GRAIN_W){1'b0}}, grain};
      end
      2'd2: begin
        coef_sel = {{(NW-CF){cc[CF-1]}}, cc};
        gpow     = {{(csp_pkg::GCU_W-csp_pkg::GSQ_W){1'b0}}, gsq};
      end
      default: begin
        coef_sel = {{(NW-CW-8){p1[CW-1]}}, p1, 8'd0};
        gpow     = gcu;
      end
    endcase
    aj     = acc * $signed({1'b0, cmd.j});
    cg     = coef_sel * $signed({1'b0, gpow});
    biased = acc + $signed({{(NW-csp_pkg::GCU_W-7){1'b0}}, gcu, 7'd0});
  end

  // divider step and final saturated result
  always_comb begin
    mag   = msig[MW-1] ? (~msig + MW'(gcu)) : msig;
    trial = {rem, q[MW-1]};
    qbit  = (trial >= {1'b0, gcu});
    if (neg) begin
      if (q > MW'(2 ** (CW - 1))) sat = {1'b1, {(CW-1){1'b0}}};
      else                         sat = -$signed(q[CW-1:0]);
    end else begin
      if (q > MW'(2 ** (CW - 1) - 1)) sat = {1'b0, {(CW-1){1'b1}}};
      else                             sat = $signed(q[CW-1:0]);
    end
  end

  // knot window
  always_ff @(posedge clk) begin
    if (cmd.load_cur) cur <= coord;
    if (cmd.fill) begin
      p0 <= cur;
      p1 <= cur;
      p2 <= cur;
    end else if (cmd.shift) begin
      p0 <= p1;
      p1 <= p2;
      p2 <= cur;
    end
  end

  // coefficients and powers of the grain
  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      case (cmd.term)
        csp_pkg::TERM_A0: ca <= prod;
        csp_pkg::TERM_A1, csp_pkg::TERM_A2, csp_pkg::TERM_A3: ca <= ca + prod;
        csp_pkg::TERM_B0: cb <= prod;
        csp_pkg::TERM_B1, csp_pkg::TERM_B2, csp_pkg::TERM_B3: cb <= cb + prod;
        csp_pkg::TERM_C0: cc <= prod;
        csp_pkg::TERM_C2: cc <= cc + prod;
        default: ;
      endcase
      if (cmd.term == csp_pkg::TERM_A0)
        gsq <= csp_pkg::GSQ_W'(grain) * csp_pkg::GSQ_W'(grain);
      if (cmd.term == csp_pkg::TERM_A1)
        gcu <= csp_pkg::GCU_W'(gsq) * csp_pkg::GCU_W'(grain);
    end
  end

  // horner numerator
  always_ff @(posedge clk) begin
    if (cmd.horn_en) begin
      if (cmd.horn_step == 2'd0) acc <= {{(NW-CF){ca[CF-1]}}, ca};
      else                       acc <= aj + cg;
    end
    if (cmd.div_init) msig <= biased[NW-1:8];
  end

  // floor division by the cube of the grain, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.div_load) begin
      busy <= 1'b1;
      cnt  <= csp_pkg::DC_W'(MW);
    end else if (busy) begin
      if (cnt != '0) cnt <= cnt - 1'b1;
      else           busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg <= msig[MW-1];
      q   <= mag;
      rem <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        q   <= {q[MW-2:0], qbit};
        rem <= qbit ? csp_pkg::GCU_W'(trial - {1'b0, gcu}) : trial[csp_pkg::GCU_W-1:0];
      end else begin
        res <= sat;
      end
    end
  end

endmodule

FILE: design/csp_ctrl.sv
module csp_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        first_point,
  input  logic                        last_point,
  input  logic                        out_free,
  input  logic [csp_pkg::GRAIN_W-1:0] grain,
  input  csp_pkg::lane_stat_t         stat,
  output logic                        in_ready,
  output csp_pkg::lane_cmd_t          cmd,
  output csp_pkg::emit_t              emit
);

  csp_pkg::state_t state, state_next;
  logic [1:0] seen, seen_next;
  logic first_f, last_f, dup, dup_next;
  csp_pkg::term_t term, term_next;
  logic [1:0] horn, horn_next;
  logic [csp_pkg::GRAIN_W-1:0] j, j_next;
  logic seg_end;

  assign seg_end = (j == grain - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csp_pkg::ST_IDLE;
      seen  <= 2'd0;
      dup   <= 1'b0;
      term  <= csp_pkg::TERM_A0;
      horn  <= 2'd0;
      j     <= '0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
      dup   <= dup_next;
      term  <= term_next;
      horn  <= horn_next;
      j     <= j_next;
    end
  end

  // flags of the word in work
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      first_f <= first_point;
      last_f  <= last_point;
    end
  end

  // sequencing
  always_comb begin
    state_next = state;
    seen_next  = seen;
    dup_next   = dup;
    term_next  = term;
    horn_next  = horn;
    j_next     = j;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.term   = term;
    cmd.horn_step = horn;
    cmd.j      = j;
    cmd.dup    = dup;
    emit       = '0;
    case (state)
      csp_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_cur = in_valid;
        if (in_valid) state_next = csp_pkg::ST_DECIDE;
      end
      csp_pkg::ST_DECIDE: begin
        term_next = csp_pkg::TERM_A0;
        if (first_f || seen == 2'd0) begin
          cmd.fill   = 1'b1;
          seen_next  = 2'd1;
          state_next = last_f ? csp_pkg::ST_POINT : csp_pkg::ST_IDLE;
        end else if (seen == 2'd1) begin
          cmd.shift  = 1'b1;
          seen_next  = 2'd2;
          dup_next   = 1'b1;
          state_next = last_f ? csp_pkg::ST_COEF : csp_pkg::ST_IDLE;
        end else begin
          seen_next  = 2'd3;
          dup_next   = 1'b0;
          state_next = csp_pkg::ST_COEF;
        end
      end
      csp_pkg::ST_COEF: begin
        cmd.mac_en = 1'b1;
        if (term == csp_pkg::TERM_C2) begin
          horn_next  = 2'd0;
          j_next     = '0;
          state_next = csp_pkg::ST_HORN;
        end else begin
          term_next = csp_pkg::term_t'(term + 1'b1);
        end
      end
      csp_pkg::ST_HORN: begin
        cmd.horn_en = 1'b1;
        horn_next   = horn + 1'b1;
        if (horn == 2'd3) state_next = csp_pkg::ST_DIV_INIT;
      end
      csp_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = csp_pkg::ST_DIV_LOAD;
      end
      csp_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = csp_pkg::ST_DIV_WAIT;
      end
      csp_pkg::ST_DIV_WAIT: begin
        if (!stat.busy) state_next = csp_pkg::ST_EMIT;
      end
      csp_pkg::ST_EMIT: begin
        if (out_free) begin
          emit.emit        = 1'b1;
          emit.last_of_run = seg_end && !last_f;
          horn_next        = 2'd0;
          if (seg_end) begin
            state_next = csp_pkg::ST_AFTER;
          end else begin
            j_next     = j + 1'b1;
            state_next = csp_pkg::ST_HORN;
          end
        end
      end
      csp_pkg::ST_AFTER: begin
        term_next = csp_pkg::TERM_A0;
        if (dup) begin
          state_next = csp_pkg::ST_POINT;
        end else begin
          cmd.shift = 1'b1;
          if (last_f) begin
            dup_next   = 1'b1;
            state_next = csp_pkg::ST_COEF;
          end else begin
            state_next = csp_pkg::ST_IDLE;
          end
        end
      end
      csp_pkg::ST_POINT: begin
        if (out_free) begin
          emit.emit        = 1'b1;
          emit.point       = 1'b1;
          emit.last_of_run = 1'b1;
          emit.curve_end   = 1'b1;
          seen_next        = 2'd0;
          state_next       = csp_pkg::ST_IDLE;
        end
      end
      default: state_next = csp_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: design/cardinal_spline_point_generator.sv
// Cardinal spline point generator: takes 2D control points (Q11.4) and emits
// points_per_segment samples (zero taken as one) per curve segment, the curve
// padded by repeating its first and last points, then the end point with
// curve_end set. A segment starts with coefficient setup on one
// multiply-accumulate per axis; each sample then takes 4 Horner steps and a
// restoring divider by 256*G^3 that yields one quotient bit a cycle over 38
// bits. A last point adds one more segment and the end point. A finished
// sample waits in the output register while the next one is computed.
// Configuration writes are taken at any time, ready high.
module cardinal_spline_point_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  csp_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output csp_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [csp_pkg::TENS_W-1:0]  tension;
  logic [csp_pkg::GRAIN_W-1:0] points_per_segment, grain;
  logic out_free;
  csp_pkg::lane_cmd_t  cmd;
  csp_pkg::lane_stat_t stat_x, stat_y, stat;
  csp_pkg::emit_t      emit;
  logic signed [csp_pkg::COORD_W-1:0] res_x, res_y, pt_x, pt_y;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign stat.busy = stat_x.busy || stat_y.busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tension            <= csp_pkg::TENSION_RST;
      points_per_segment <= csp_pkg::POINTS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == csp_pkg::REG_TENSION) tension <= cfg_data;
      if (cfg_index == csp_pkg::REG_POINTS)
        points_per_segment <= cfg_data[csp_pkg::GRAIN_W-1:0];
    end
  end

  // samples per segment, kept in range
  always_comb begin
    if (points_per_segment == '0)
      grain = csp_pkg::GRAIN_W'(1);
    else if (points_per_segment > csp_pkg::GRAIN_W'(csp_pkg::MAX_SAMPLES))
      grain = csp_pkg::GRAIN_W'(csp_pkg::MAX_SAMPLES);
    else
      grain = points_per_segment;
  end

  csp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .first_point (in_data.first_point),
    .last_point  (in_data.last_point),
    .out_free    (out_free),
    .grain       (grain),
    .stat        (stat),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .emit        (emit)
  );

  csp_lane u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .coord   (in_data.x_in),
    .tension (tension),
    .grain   (grain),
    .stat    (stat_x),
    .res     (res_x),
    .pt      (pt_x)
  );

  csp_lane u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .coord   (in_data.y_in),
    .tension (tension),
    .grain   (grain),
    .stat    (stat_y),
    .res     (res_y),
    .pt      (pt_y)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit) begin
      out_data.x_out       <= emit.point ? pt_x : res_x;
      out_data.y_out       <= emit.point ? pt_y : res_y;
      out_data.last_of_run <= emit.last_of_run;
      out_data.curve_end   <= emit.curve_end;
    end
  end

endmodule
